### src/fts_pkg.sv
// fts_pkg: shared types and constants for the floor take sorted table
// holds the item value width, op and status codes, and the sequencer states
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fts_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_TAKE   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_FULL     = 2'd1,
    ST_NONE     = 2'd2,
    ST_TAKEN    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE_RD,
    S_MOVE_WR,
    S_DONE
  } fsm_t;

endpackage

`default_nettype wire

### src/fts_if.sv
// fts_req_if and fts_rsp_if: valid/ready channels for request and result items
// depends on fts_pkg for field types
`timescale 1ns / 1ps
`default_nettype none

interface fts_req_if import fts_pkg::*; ();
  logic               valid;
  logic               ready;
  op_t                op;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink (input valid, input op, input value, output ready);
endinterface

interface fts_rsp_if import fts_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [VALUE_W-1:0] price;

  modport source (output valid, output status, output price, input ready);
  modport sink (input valid, input status, input price, output ready);
endinterface

`default_nettype wire

### src/fts_store.sv
// fts_store: price memory, one write port and one read port with registered data
// no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module fts_store #(
  parameter int DEPTH = 1024,
  parameter int PW    = 32,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [PW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [PW-1:0] rdata
);

  logic [PW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/fts_cmp.sv
// fts_cmp: shared compare unit used once per scanned entry
// decides whether a candidate fits at or under the limit and beats the current best (or no best is found yet)
`timescale 1ns / 1ps
`default_nettype none

module fts_cmp #(
  parameter int PW = 32
) (
  input  wire logic [PW-1:0] cand,
  input  wire logic [PW-1:0] limit,
  input  wire logic [PW-1:0] best,
  input  wire logic          found,
  output logic               better
);

  logic qual;

  assign qual   = (cand <= limit);
  assign better = qual && (!found || (cand > best));

endmodule

`default_nettype wire

### src/floor_take_sorted_table.sv
// floor_take_sorted_table: multiset of prices with insert and floor take
// an insert writes at the fill count; a take scans every filled entry (one read per entry)
// and, when a price fits, moves the last entry into the taken slot (move read, move write);
// a new request is accepted only in idle, once the last result is loaded for output;
// a stalled result holds the sequencer in its last state; store is packed, fill count
// synchronous reset empties the table at once; no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module floor_take_sorted_table import fts_pkg::*; #(
  parameter int DEPTH       = 1024,
  parameter int PRICE_WIDTH = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  fts_req_if.sink   req,
  fts_rsp_if.source rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = PRICE_WIDTH;

  fsm_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] scan_addr;
  logic [CW-1:0] last;
  logic [AW-1:0] rd_idx;
  logic [AW-1:0] best_idx;
  logic [PW-1:0] best;
  logic [PW-1:0] limit;
  logic [PW-1:0] req_price;
  logic [PW-1:0] rdata;
  logic          found;
  logic          pend;
  logic          issue;
  logic          better;
  logic          full;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [PW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;

  status_t            res_status;
  logic [VALUE_W-1:0] res_price;
  logic               out_valid;
  status_t            out_status;
  logic [VALUE_W-1:0] out_price;
  logic               load_out;

  logic [PW+VALUE_W-1:0] in_ext;
  logic [PW+VALUE_W-1:0] best_ext;

  assign in_ext    = {{PW{1'b0}}, req.value};
  assign req_price = in_ext[PW-1:0];
  assign best_ext  = {{VALUE_W{1'b0}}, best};
  assign last      = count - CW'(1);
  assign full      = (count == CW'(DEPTH));

  fts_store #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  fts_cmp #(
    .PW (PW)
  ) u_cmp (
    .cand   (rdata),
    .limit  (limit),
    .best   (best),
    .found  (found),
    .better (better)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = count[AW-1:0];
    mem_wdata  = req_price;
    mem_raddr  = scan_addr[AW-1:0];
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          if (req.op == OP_INSERT) begin
            mem_we     = !full;
            state_next = S_DONE;
          end else if (count == '0) begin
            state_next = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        issue = (scan_addr != count);
        if (!issue && !pend) begin
          state_next = found ? S_MOVE_RD : S_DONE;
        end
      end
      S_MOVE_RD: begin
        mem_raddr  = last[AW-1:0];
        state_next = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        mem_we     = 1'b1;
        mem_waddr  = best_idx;
        mem_wdata  = rdata;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || rsp.ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign req.ready = (state == S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      scan_addr <= '0;
      found     <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= issue;
      if (state == S_IDLE && req.valid) begin
        if (req.op == OP_INSERT && !full) begin
          count <= count + CW'(1);
        end
        scan_addr <= '0;
        found     <= 1'b0;
      end
      if (issue) begin
        scan_addr <= scan_addr + CW'(1);
      end
      if (state == S_SCAN && pend && better) begin
        found <= 1'b1;
      end
      if (state == S_MOVE_WR) begin
        count <= last;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      limit     <= req_price;
      res_price <= '0;
      if (req.op == OP_INSERT) begin
        res_status <= full ? ST_FULL : ST_INSERTED;
      end else begin
        res_status <= ST_NONE;
      end
    end
    if (issue) begin
      rd_idx <= scan_addr[AW-1:0];
    end
    if (state == S_SCAN && pend && better) begin
      best     <= rdata;
      best_idx <= rd_idx;
    end
    if (state == S_MOVE_WR) begin
      res_status <= ST_TAKEN;
      res_price  <= best_ext[VALUE_W-1:0];
    end
    if (load_out) begin
      out_status <= res_status;
      out_price  <= res_price;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.price  = out_price;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count == $past(count)) || (count == $past(count) + CW'(1)) ||
    (count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_best_under_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_MOVE_WR) |-> (found && (best <= limit)))
    else $error("taken price above limit");

  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && pend) |-> ({1'b0, rd_idx} < {1'b0, count}))
    else $error("scan read beyond filled entries");

  a_no_load_over_full: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!out_valid || rsp.ready))
    else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

### sim/price_book_pkg.sv
// price_book_pkg: scoreboard class that tracks the price multiset and checks results
// depends on fts_pkg for op and status codes and the value width
`timescale 1ns / 1ps

package price_book_pkg;
  import fts_pkg::*;

  typedef struct packed {
    status_t            status;
    logic [VALUE_W-1:0] price;
  } reply_t;

  class price_book;
    logic [VALUE_W-1:0] held_prices[$];
    reply_t             pending_replies[$];
    int unsigned        capacity;
    int unsigned        errors;

    function new(int unsigned capacity);
      this.capacity = capacity;
      errors = 0;
    endfunction

    function int unsigned stored_count();
      return held_prices.size();
    endfunction

    function int unsigned pending_count();
      return pending_replies.size();
    endfunction

    function logic [VALUE_W-1:0] sample_price();
      if (held_prices.size() == 0) begin
        return $urandom;
      end
      return held_prices[$urandom_range(0, held_prices.size() - 1)];
    endfunction

    function void note_order(op_t op, logic [VALUE_W-1:0] value);
      int     best;
      reply_t want;
      best = -1;
      want.price = '0;
      if (op == OP_INSERT) begin
        if (held_prices.size() >= capacity) begin
          want.status = ST_FULL;
        end else begin
          held_prices.insert(held_prices.size(), value);
          want.status = ST_INSERTED;
        end
      end else begin
        foreach (held_prices[i]) begin
          if (held_prices[i] <= value && (best < 0 || held_prices[i] > held_prices[best])) begin
            best = i;
          end
        end
        if (best < 0) begin
          want.status = ST_NONE;
        end else begin
          want.status = ST_TAKEN;
          want.price  = held_prices[best];
          held_prices.delete(best);
        end
      end
      pending_replies.insert(pending_replies.size(), want);
    endfunction

    function void check_reply(status_t status, logic [VALUE_W-1:0] price);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result item: status %0d price %0h", status, price);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status) begin
        $error("field status: expected %0d actual %0d", want.status, status);
        errors++;
      end
      if (price !== want.price) begin
        $error("field price: expected %0h actual %0h", want.price, price);
        errors++;
      end
    endfunction
  endclass

endpackage

### sim/tb_top.sv
// tb_top: testbench for floor_take_sorted_table, directed and random insert/take items
// with random idling on both channels, a long result hold-off and an idle-free last stretch
// depends on fts_pkg, fts_if and price_book_pkg
`timescale 1ns / 1ps

module tb_top;
  import fts_pkg::*;
  import price_book_pkg::*;

  localparam int TABLE_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 560;
  localparam int QUIET_ITEMS  = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = TABLE_DEPTH + 64;
  localparam int CYCLE_LIMIT  = 2000000;

  logic clk;
  logic rst;
  bit   gap_on;
  bit   stall_on;
  bit   hold_req;
  bit   hold_done;
  int unsigned cycle_count;
  price_book book;

  fts_req_if req_ch ();
  fts_rsp_if rsp_ch ();

  floor_take_sorted_table #(
    .DEPTH       (TABLE_DEPTH),
    .PRICE_WIDTH (VALUE_W)
  ) DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial book = new(TABLE_DEPTH);

  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        book.note_order(req_ch.op, req_ch.value);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        book.check_reply(rsp_ch.status, rsp_ch.price);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("floor_take_sorted_table test failed");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (stall_on && $urandom_range(0, 5) == 0) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send_order(input op_t op, input logic [VALUE_W-1:0] value);
    if (gap_on && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] pick_price();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 255);
      2: return 32'hFFFF_FF00 | $urandom_range(0, 255);
      default: return $urandom_range(0, 3) == 0 ? '1 : '0;
    endcase
  endfunction

  initial begin
    int unsigned         take_odds;
    logic [VALUE_W-1:0]  limit;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_INSERT;
    req_ch.value <= '0;
    gap_on   = 1'b1;
    stall_on = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, extremes, duplicates, nothing below the limit
    send_order(OP_TAKE, 32'h0000_0000);
    send_order(OP_TAKE, 32'hFFFF_FFFF);
    send_order(OP_INSERT, 32'h0000_0000);
    send_order(OP_INSERT, 32'hFFFF_FFFF);
    send_order(OP_INSERT, 32'd100);
    send_order(OP_INSERT, 32'd100);
    send_order(OP_INSERT, 32'd50);
    send_order(OP_TAKE, 32'd49);
    send_order(OP_TAKE, 32'd49);
    send_order(OP_TAKE, 32'd100);
    send_order(OP_TAKE, 32'd100);
    send_order(OP_TAKE, 32'd99);
    send_order(OP_TAKE, 32'hFFFF_FFFE);
    send_order(OP_TAKE, 32'hFFFF_FFFF);
    send_order(OP_INSERT, 32'hAAAA_AAAA);
    send_order(OP_INSERT, 32'h5555_5555);
    send_order(OP_TAKE, 32'hFFFF_FFFF);
    send_order(OP_TAKE, 32'h5555_5555);
    send_order(OP_TAKE, 32'h5555_5554);

    // random mix, table kept small so takes stay short
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) begin
        hold_req = 1'b1;
      end
      if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
        gap_on   = 1'b0;
        stall_on = 1'b0;
      end
      if (book.stored_count() < 8) begin
        take_odds = 30;
      end else if (book.stored_count() > 48) begin
        take_odds = 80;
      end else begin
        take_odds = 50;
      end
      if ($urandom_range(0, 99) < take_odds) begin
        case ($urandom_range(0, 4))
          0: limit = pick_price();
          1: limit = book.sample_price();
          2: limit = book.sample_price() - 1;
          3: limit = book.sample_price() + $urandom_range(1, 3);
          default: limit = $urandom_range(0, 1) ? '1 : '0;
        endcase
        send_order(OP_TAKE, limit);
      end else begin
        send_order(OP_INSERT, pick_price());
      end
    end

    // last stretch, no idling
    send_order(OP_INSERT, 32'hFFFF_FFFF);
    send_order(OP_INSERT, 32'h0000_0000);
    send_order(OP_TAKE, 32'hFFFF_FFFF);
    send_order(OP_TAKE, book.sample_price());
    send_order(OP_TAKE, 32'h0000_0000);
    send_order(OP_TAKE, $urandom);
    req_ch.valid <= 1'b0;

    while (book.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.errors == 0) begin
      $display("floor_take_sorted_table test passed");
    end else begin
      $display("floor_take_sorted_table test failed");
    end
    $finish;
  end

endmodule
